>>> src/assert_macros.svh
// Clocked assertion helpers; every use runs off clk and is muted in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define C8_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define C8_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/c8_pkg.sv
package c8_pkg;

  localparam int MEMORY_BYTES     = 4096;
  localparam int MEM_AW           = $clog2(MEMORY_BYTES);
  localparam int STACK_LEVELS_DEF = 16;
  localparam int SCREEN_WIDTH     = 64;
  localparam int SCREEN_HEIGHT    = 32;
  localparam int DISP_ROWS        = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int DISP_AW          = $clog2(DISP_ROWS);
  localparam logic [11:0] PC_RESET = 12'h200;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_EXEC = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OVF = 2'd2,
    ST_UNF = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OC_CLS, OC_RET, OC_JP, OC_CALL, OC_SKIP, OC_SETX, OC_FLAG, OC_SETI,
    OC_JPV0, OC_DRAW, OC_TIMER, OC_BCD, OC_STORE, OC_LOAD, OC_BAD
  } opcls_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic disp_rd;
    logic fetch_hi;
    logic fetch_lo;
    logic rd_x;
    logic rd_y;
    logic rd_0;
    logic exec;
    logic wr_x;
    logic bcd_wr;
    logic st_rd;
    logic st_wr;
    logic ld_rd;
    logic ld_wr;
    logic dr_mem;
    logic dr_ra;
    logic dr_wa;
    logic dr_wb;
    logic fin;
  } cmd_t;

  typedef struct packed {
    kind_t  kind;
    opcls_t cls;
    logic   err;
    logic   last;
    logic   empty;
    logic   out_free;
  } stat_t;

  function automatic opcls_t op_decode(input logic [15:0] op);
    opcls_t c;
    c = OC_BAD;
    unique case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) c = OC_CLS;
        else if (op == 16'h00EE) c = OC_RET;
      end
      4'h1: c = OC_JP;
      4'h2: c = OC_CALL;
      4'h3, 4'h4: c = OC_SKIP;
      4'h5, 4'h9: begin
        if (op[3:0] == 4'h0) c = OC_SKIP;
      end
      4'h6, 4'h7, 4'hC: c = OC_SETX;
      4'h8: begin
        if (op[3:2] == 2'b00) c = OC_SETX;
        else if (op[3:0] == 4'h4 || op[3:0] == 4'h5 || op[3:0] == 4'h6 ||
                 op[3:0] == 4'h7 || op[3:0] == 4'hE) c = OC_FLAG;
      end
      4'hA: c = OC_SETI;
      4'hB: c = OC_JPV0;
      4'hD: c = OC_DRAW;
      4'hE: begin
        if (op[7:0] == 8'h9E || op[7:0] == 8'hA1) c = OC_SKIP;
      end
      4'hF: begin
        if (op[7:0] == 8'h07 || op[7:0] == 8'h0A) c = OC_SETX;
        else if (op[7:0] == 8'h15 || op[7:0] == 8'h18) c = OC_TIMER;
        else if (op[7:0] == 8'h1E || op[7:0] == 8'h29) c = OC_SETI;
        else if (op[7:0] == 8'h33) c = OC_BCD;
        else if (op[7:0] == 8'h55) c = OC_STORE;
        else if (op[7:0] == 8'h65) c = OC_LOAD;
      end
    endcase
    return c;
  endfunction

endpackage

>>> src/c8_if.sv
interface c8_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] address;
  logic [7:0]  data;
  logic [15:0] keys_down;
  logic [7:0]  random_byte;
  logic [3:0]  waited_key;

  modport source (output valid, kind, address, data, keys_down, random_byte, waited_key,
                  input ready);
  modport sink (input valid, kind, address, data, keys_down, random_byte, waited_key,
                output ready);
endinterface

interface c8_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [15:0] executed_opcode;
  logic [1:0]  status;
  logic        sound_active;
  logic        display_changed;
  logic [7:0]  read_byte;

  modport source (output valid, program_counter, executed_opcode, status, sound_active,
                  display_changed, read_byte, input ready);
  modport sink (input valid, program_counter, executed_opcode, status, sound_active,
                display_changed, read_byte, output ready);
endinterface

>>> src/c8_dp.sv
module c8_dp #(
  parameter int STACK_LEVELS = c8_pkg::STACK_LEVELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  c8_pkg::cmd_t  cmd,
  output c8_pkg::stat_t stat,
  input  logic [1:0]    in_kind,
  input  logic [11:0]   in_address,
  input  logic [7:0]    in_data,
  input  logic [15:0]   in_keys_down,
  input  logic [7:0]    in_random_byte,
  input  logic [3:0]    in_waited_key,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [11:0]   out_program_counter,
  output logic [15:0]   out_executed_opcode,
  output logic [1:0]    out_status,
  output logic          out_sound_active,
  output logic          out_display_changed,
  output logic [7:0]    out_read_byte
);
  import c8_pkg::*;

  localparam int SW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
  localparam int DW = $clog2(STACK_LEVELS + 1);

  function automatic logic [23:0] bcd3(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - (8'(h) * 8'd100);
    p = 15'(r[6:0]) * 15'd205;
    t = p[14:11];
    o = r - (8'(t) * 8'd10);
    return {6'b0, h, 4'b0, t, o};
  endfunction

  kind_t       kind_r;
  logic [11:0] addr_r;
  logic [7:0]  data_r;
  logic [15:0] keys_r;
  logic [7:0]  rnd_r;
  logic [3:0]  wkey_r;

  logic [11:0]   pc_r;
  logic [15:0]   i_r;
  logic [7:0]    dly_r;
  logic [7:0]    snd_r;
  logic [DW-1:0] depth_r;

  logic [15:0] op_r;
  logic [7:0]  vx_r;
  logic [7:0]  vy_r;
  logic [7:0]  res_r;
  logic [7:0]  spr_r;
  logic [11:0] nextpc_r;
  status_t     status_r;
  logic [3:0]  cnt_r;
  logic        coll_r;
  logic        chg_r;

  logic [7:0]  mem [MEMORY_BYTES];
  logic [7:0]  mem_q;
  logic        mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  logic [7:0]  vr [16];
  logic [15:0] vvalid_r;
  logic [7:0]  reg_q;
  logic        rf_we;
  logic [3:0]  rf_wa, rf_ra;
  logic [7:0]  rf_wd;

  logic [11:0]   stk [STACK_LEVELS];
  logic [11:0]   stk_q;
  logic          stk_we;
  logic [DW-1:0] depth_m1;

  logic [7:0]  disp [DISP_ROWS];
  logic [DISP_ROWS-1:0] dvalid_r;
  logic [7:0]  disp_q;
  logic        d_re, d_we;
  logic [DISP_AW-1:0] d_ra, d_wa, row_a, row_b;
  logic [7:0]  d_wd, d_mask;
  logic        hit, turn_on, coll_all;

  logic [3:0]  x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  opcls_t      cls;
  status_t     st_exec;
  logic        key, skip;
  logic [11:0] nextpc;
  logic [7:0]  setx_val, flag_res;
  logic        flag;
  logic [8:0]  sum9;
  logic [23:0] digits;
  logic [7:0]  digit;
  logic [11:0] ia;
  logic [7:0]  xc, yc;
  logic [8:0]  py;
  logic        draw_ok;
  logic [15:0] mask16;
  logic [7:0]  m_a, m_b;
  logic        push, commit;

  assign x   = op_r[11:8];
  assign y   = op_r[7:4];
  assign n   = op_r[3:0];
  assign nn  = op_r[7:0];
  assign nnn = op_r[11:0];
  assign cls = op_decode(op_r);
  assign ia  = i_r[11:0] + 12'(cnt_r);

  always_comb begin
    st_exec = ST_OK;
    if (cls == OC_BAD) st_exec = ST_BAD;
    else if (cls == OC_RET && depth_r == '0) st_exec = ST_UNF;
    else if (cls == OC_CALL && depth_r >= DW'(STACK_LEVELS)) st_exec = ST_OVF;
  end

  assign key = (vx_r[7:4] == 4'h0) && keys_r[vx_r[3:0]];

  always_comb begin
    unique case (op_r[15:12])
      4'h3:    skip = (vx_r == nn);
      4'h4:    skip = (vx_r != nn);
      4'h5:    skip = (vx_r == vy_r);
      4'h9:    skip = (vx_r != vy_r);
      4'hE:    skip = (nn == 8'h9E) ? key : !key;
      default: skip = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cls)
      OC_JP, OC_CALL: nextpc = nnn;
      OC_RET:         nextpc = stk_q + 12'd2;
      OC_JPV0:        nextpc = nnn + {4'b0, reg_q};
      OC_SKIP:        nextpc = skip ? (pc_r + 12'd4) : (pc_r + 12'd2);
      default:        nextpc = pc_r + 12'd2;
    endcase
  end

  always_comb begin
    unique case (op_r[15:12])
      4'h6: setx_val = nn;
      4'h7: setx_val = vx_r + nn;
      4'h8: begin
        unique case (n[1:0])
          2'd0: setx_val = vy_r;
          2'd1: setx_val = vx_r | vy_r;
          2'd2: setx_val = vx_r & vy_r;
          2'd3: setx_val = vx_r ^ vy_r;
        endcase
      end
      4'hC: setx_val = rnd_r & nn;
      4'hF: setx_val = (nn == 8'h07) ? dly_r : {4'b0, wkey_r};
      default: setx_val = nn;
    endcase
  end

  assign sum9 = {1'b0, vx_r} + {1'b0, vy_r};

  always_comb begin
    unique case (n)
      4'h4: begin
        flag = sum9[8];
        flag_res = sum9[7:0];
      end
      4'h5: begin
        flag = (vx_r > vy_r);
        flag_res = vx_r - vy_r;
      end
      4'h6: begin
        flag = vx_r[0];
        flag_res = {1'b0, vx_r[7:1]};
      end
      4'h7: begin
        flag = (vy_r > vx_r);
        flag_res = vy_r - vx_r;
      end
      default: begin
        flag = vx_r[7];
        flag_res = {vx_r[6:0], 1'b0};
      end
    endcase
  end

  assign digits = bcd3(vx_r);
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    digit = digits[23:16];
      2'd1:    digit = digits[15:8];
      default: digit = digits[7:0];
    endcase
  end

  assign xc      = (x == 4'hF) ? 8'h00 : vx_r;
  assign yc      = (y == 4'hF) ? 8'h00 : vy_r;
  assign py      = {1'b0, yc} + 9'(cnt_r);
  assign draw_ok = (xc[7:6] == 2'b00) && (py[8:5] == 4'h0);
  assign mask16  = {spr_r, 8'h00} >> xc[2:0];
  assign m_a     = draw_ok ? mask16[15:8] : 8'h00;
  assign m_b     = (draw_ok && xc[5:3] != 3'd7) ? mask16[7:0] : 8'h00;
  assign row_a   = {py[4:0], xc[5:3]};
  assign row_b   = row_a + DISP_AW'(1);

  always_comb begin
    stat.kind     = kind_r;
    stat.cls      = cls;
    stat.err      = (st_exec != ST_OK);
    stat.empty    = (n == 4'h0);
    stat.out_free = !out_valid || out_ready;
    unique case (cls)
      OC_BCD:            stat.last = (cnt_r == 4'd2);
      OC_STORE, OC_LOAD: stat.last = (cnt_r == x);
      OC_DRAW:           stat.last = (cnt_r == n - 4'd1);
      default:           stat.last = 1'b1;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ia;
    mem_wd = reg_q;
    if (cmd.load_wr) begin
      mem_we = 1'b1;
      mem_wa = addr_r;
      mem_wd = data_r;
    end else if (cmd.bcd_wr) begin
      mem_we = 1'b1;
      mem_wd = digit;
    end else if (cmd.st_wr) begin
      mem_we = 1'b1;
    end
    if (cmd.fetch_lo) mem_ra = pc_r + 12'd1;
    else if (cmd.ld_rd || cmd.dr_mem) mem_ra = ia;
    else mem_ra = pc_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  assign coll_all = coll_r | hit;

  always_comb begin
    rf_we = 1'b0;
    rf_wa = x;
    rf_wd = setx_val;
    if (cmd.exec) begin
      if (cls == OC_SETX) begin
        rf_we = 1'b1;
      end else if (cls == OC_FLAG) begin
        rf_we = 1'b1;
        rf_wa = 4'hF;
        rf_wd = {7'b0, flag};
      end else if (cls == OC_DRAW) begin
        rf_we = 1'b1;
        rf_wa = 4'hF;
        rf_wd = 8'h00;
      end
    end else if (cmd.wr_x) begin
      rf_we = 1'b1;
      rf_wd = res_r;
    end else if (cmd.ld_wr) begin
      rf_we = 1'b1;
      rf_wa = cnt_r;
      rf_wd = mem_q;
    end else if (cmd.dr_wb && stat.last) begin
      rf_we = 1'b1;
      rf_wa = 4'hF;
      rf_wd = {7'b0, coll_all};
    end
    if (cmd.rd_x) rf_ra = x;
    else if (cmd.rd_y) rf_ra = y;
    else if (cmd.st_rd) rf_ra = cnt_r;
    else rf_ra = 4'h0;
  end

  always_ff @(posedge clk) begin
    if (rf_we) vr[rf_wa] <= rf_wd;
    reg_q <= vvalid_r[rf_ra] ? vr[rf_ra] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vvalid_r <= '0;
    end else if (rf_we) begin
      vvalid_r[rf_wa] <= 1'b1;
    end
  end

  assign stk_we   = cmd.exec && cls == OC_CALL && st_exec == ST_OK;
  assign depth_m1 = depth_r - DW'(1);

  always_ff @(posedge clk) begin
    if (stk_we) stk[depth_r[SW-1:0]] <= pc_r;
    if (cmd.rd_x) stk_q <= stk[depth_m1[SW-1:0]];
  end

  assign d_re   = cmd.disp_rd || cmd.dr_ra || cmd.dr_wa;
  assign d_ra   = cmd.disp_rd ? addr_r[DISP_AW-1:0] : (cmd.dr_ra ? row_a : row_b);
  assign d_we   = cmd.dr_wa || cmd.dr_wb;
  assign d_wa   = cmd.dr_wa ? row_a : row_b;
  assign d_mask = cmd.dr_wa ? m_a : m_b;
  assign d_wd   = disp_q ^ d_mask;
  assign hit     = d_we && ((disp_q & d_mask) != 8'h00);
  assign turn_on = d_we && ((~disp_q & d_mask) != 8'h00);

  always_ff @(posedge clk) begin
    if (d_we) disp[d_wa] <= d_wd;
    if (d_re) disp_q <= dvalid_r[d_ra] ? disp[d_ra] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r <= '0;
    end else if (cmd.exec && cls == OC_CLS) begin
      dvalid_r <= '0;
    end else if (d_we) begin
      dvalid_r[d_wa] <= 1'b1;
    end
  end

  assign push   = cmd.fin && stat.out_free;
  assign commit = (kind_r == KIND_EXEC) && (status_r == ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind_t'(in_kind);
      addr_r <= in_address;
      data_r <= in_data;
      keys_r <= in_keys_down;
      rnd_r  <= in_random_byte;
      wkey_r <= in_waited_key;
      status_r <= ST_OK;
    end
    if (cmd.fetch_lo) op_r[15:8] <= mem_q;
    if (cmd.rd_x) op_r[7:0] <= mem_q;
    if (cmd.rd_y) vx_r <= reg_q;
    if (cmd.rd_0) vy_r <= reg_q;
    if (cmd.dr_ra) spr_r <= mem_q;
    if (cmd.exec) begin
      status_r <= st_exec;
      nextpc_r <= nextpc;
      res_r    <= flag_res;
    end
    if (cmd.capture || cmd.exec) begin
      cnt_r  <= 4'h0;
      coll_r <= 1'b0;
      chg_r  <= 1'b0;
    end else begin
      if (cmd.bcd_wr || cmd.st_wr || cmd.ld_wr || cmd.dr_wb) cnt_r <= cnt_r + 4'd1;
      if (d_we) begin
        coll_r <= coll_r | hit;
        chg_r  <= chg_r | turn_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= PC_RESET;
      i_r     <= 16'h0000;
      dly_r   <= 8'h00;
      snd_r   <= 8'h00;
      depth_r <= '0;
    end else begin
      if (cmd.exec && st_exec == ST_OK) begin
        if (cls == OC_SETI) begin
          if (op_r[15:12] == 4'hA) i_r <= {4'b0, nnn};
          else if (nn == 8'h1E) i_r <= i_r + {8'b0, vx_r};
          else i_r <= {8'b0, vx_r} * 16'd5;
        end
        if (cls == OC_TIMER) begin
          if (nn == 8'h15) dly_r <= vx_r;
          else snd_r <= vx_r;
        end
        if (cls == OC_CALL) depth_r <= depth_r + DW'(1);
        if (cls == OC_RET) depth_r <= depth_m1;
      end
      if (push && commit) begin
        pc_r <= nextpc_r;
        if (dly_r != 8'h00) dly_r <= dly_r - 8'd1;
        if (snd_r != 8'h00) snd_r <= snd_r - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_program_counter <= commit ? nextpc_r : pc_r;
      out_executed_opcode <= (kind_r == KIND_EXEC) ? op_r : 16'h0000;
      out_status          <= (kind_r == KIND_EXEC) ? status_r : ST_OK;
      out_sound_active    <= commit && (snd_r != 8'h00);
      out_display_changed <= commit && chg_r;
      out_read_byte       <= (kind_r == KIND_READ && addr_r[11:DISP_AW] == '0) ?
                             disp_q : 8'h00;
    end
  end

endmodule

>>> src/c8_ctrl.sv
module c8_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  c8_pkg::stat_t stat,
  output c8_pkg::cmd_t  cmd
);
  import c8_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_DISP = 19'h00002,
    S_FHI  = 19'h00004,
    S_FLO  = 19'h00008,
    S_RX   = 19'h00010,
    S_RY   = 19'h00020,
    S_R0   = 19'h00040,
    S_EXEC = 19'h00080,
    S_WRX  = 19'h00100,
    S_BCD  = 19'h00200,
    S_STRD = 19'h00400,
    S_STWR = 19'h00800,
    S_LDRD = 19'h01000,
    S_LDWR = 19'h02000,
    S_DRM  = 19'h04000,
    S_DRA  = 19'h08000,
    S_DWA  = 19'h10000,
    S_DWB  = 19'h20000,
    S_FIN  = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (stat.kind)
          KIND_LOAD: begin
            cmd.load_wr = 1'b1;
            state_nxt = S_FIN;
          end
          KIND_READ: begin
            cmd.disp_rd = 1'b1;
            state_nxt = S_FIN;
          end
          KIND_EXEC: state_nxt = S_FHI;
          default:   state_nxt = S_FIN;
        endcase
      end
      S_FHI: begin
        cmd.fetch_hi = 1'b1;
        state_nxt = S_FLO;
      end
      S_FLO: begin
        cmd.fetch_lo = 1'b1;
        state_nxt = S_RX;
      end
      S_RX: begin
        cmd.rd_x = 1'b1;
        state_nxt = S_RY;
      end
      S_RY: begin
        cmd.rd_y = 1'b1;
        state_nxt = S_R0;
      end
      S_R0: begin
        cmd.rd_0 = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.err) begin
          state_nxt = S_FIN;
        end else begin
          unique case (stat.cls)
            OC_FLAG:  state_nxt = S_WRX;
            OC_BCD:   state_nxt = S_BCD;
            OC_STORE: state_nxt = S_STRD;
            OC_LOAD:  state_nxt = S_LDRD;
            OC_DRAW:  state_nxt = stat.empty ? S_FIN : S_DRM;
            default:  state_nxt = S_FIN;
          endcase
        end
      end
      S_WRX: begin
        cmd.wr_x = 1'b1;
        state_nxt = S_FIN;
      end
      S_BCD: begin
        cmd.bcd_wr = 1'b1;
        if (stat.last) state_nxt = S_FIN;
      end
      S_STRD: begin
        cmd.st_rd = 1'b1;
        state_nxt = S_STWR;
      end
      S_STWR: begin
        cmd.st_wr = 1'b1;
        state_nxt = stat.last ? S_FIN : S_STRD;
      end
      S_LDRD: begin
        cmd.ld_rd = 1'b1;
        state_nxt = S_LDWR;
      end
      S_LDWR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = stat.last ? S_FIN : S_LDRD;
      end
      S_DRM: begin
        cmd.dr_mem = 1'b1;
        state_nxt = S_DRA;
      end
      S_DRA: begin
        cmd.dr_ra = 1'b1;
        state_nxt = S_DWA;
      end
      S_DWA: begin
        cmd.dr_wa = 1'b1;
        state_nxt = S_DWB;
      end
      S_DWB: begin
        cmd.dr_wb = 1'b1;
        state_nxt = stat.last ? S_FIN : S_DRM;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/chip8_instruction_step_top.sv
// CHIP-8 instruction step engine.
// in_bus carries one item per beat: kind 0 stores a memory byte, kind 1 runs
// the instruction at PC, kind 2 returns one display byte, kind 3 only echoes PC.
// out_bus returns exactly one result beat per input beat, in order.
// One item is in flight at a time; in_bus.ready is high only while idle.
// Load, read and unused kinds go straight to the finish state; instructions
// fetch the opcode, read VX, VY and V0, then execute. Flag ALU ops then write
// VX back, BCD writes three digits, register block moves read and write each
// of V0-VX in turn, and sprite draws read and write each of N rows. Main memory
// and the register file each have one read port. The next input beat is taken
// in the cycle after the result register loads, never before.
// The result sits in an output register: the next input beat is accepted
// while it still waits, and a stalled receiver holds the engine only once
// the following result is ready.
// Reset (synchronous, active low) sets PC to 0x200, clears V0-VF, I, the
// timers, the stack depth and the display at once; main memory and the
// return stack keep their contents and must be written before use.
`include "assert_macros.svh"

module chip8_instruction_step_top #(
  parameter int STACK_LEVELS = c8_pkg::STACK_LEVELS_DEF
) (
  input logic    clk,
  input logic    rst_n,
  c8_in_if.sink  in_bus,
  c8_out_if.source out_bus
);
  import c8_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  c8_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  c8_dp #(
    .STACK_LEVELS (STACK_LEVELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_kind             (in_bus.kind),
    .in_address          (in_bus.address),
    .in_data             (in_bus.data),
    .in_keys_down        (in_bus.keys_down),
    .in_random_byte      (in_bus.random_byte),
    .in_waited_key       (in_bus.waited_key),
    .out_valid           (out_bus.valid),
    .out_ready           (out_bus.ready),
    .out_program_counter (out_bus.program_counter),
    .out_executed_opcode (out_bus.executed_opcode),
    .out_status          (out_bus.status),
    .out_sound_active    (out_bus.sound_active),
    .out_display_changed (out_bus.display_changed),
    .out_read_byte       (out_bus.read_byte)
  );

  `C8_ASSERT_NXT(a_busy_after_beat, in_bus.valid && in_bus.ready, !in_bus.ready, "ready after accepted beat")
  `C8_ASSERT_NXT(a_err_to_fin, cmd.exec && stat.err, cmd.fin, "faulting instruction did not finish")
  `C8_ASSERT_NXT(a_push_shows, cmd.fin && stat.out_free, out_bus.valid, "finished result not shown")
  `C8_ASSERT_IMP(a_rise_from_fin, $rose(out_bus.valid), $past(cmd.fin), "result without finish")

endmodule
